// ----- hdl/guided_robot_mode_and_steering_top_defines.svh -----
// assertion macros shared by the guided robot mode and steering rtl
// no dependencies; included by the files that carry assertions
`ifndef GUIDED_ROBOT_MODE_AND_STEERING_TOP_DEFINES_SVH
`define GUIDED_ROBOT_MODE_AND_STEERING_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GRMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GRMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/grms_pkg.sv -----
// shared types, codes and reset constants for the mode and steering controller
// no dependencies
`timescale 1ns / 1ps

package grms_pkg;

   // operating modes
   localparam logic [1:0] MODE_FOLLOW = 2'd0;
   localparam logic [1:0] MODE_DWELL1 = 2'd1;
   localparam logic [1:0] MODE_DWELL2 = 2'd2;
   localparam logic [1:0] MODE_WAIT   = 2'd3;

   // request kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_STOP = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DWELL  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_DWELL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_DUTY    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_DUTY    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIVOT_DUTY   = 3'd4;

   localparam int unsigned CSR_DATA_W = 16;

   // reset values
   localparam logic [15:0] DWELL_RESET = 16'd100;
   localparam logic [6:0]  FAST_RESET  = 7'd80;
   localparam logic [6:0]  SLOW_RESET  = 7'd60;
   localparam logic [6:0]  PIVOT_RESET = 7'd70;
   localparam logic [6:0]  RIGHT_RESET = 7'd70;
   localparam logic [6:0]  LEFT_RESET  = 7'd80;
   localparam logic [6:0]  DUTY_OFF    = 7'd0;

   typedef struct packed {
      logic func;
      logic station_button;
      logic resume_button;
      logic phase_front;
      logic phase_back;
      logic continue_button;
   } req_type;

   typedef struct packed {
      logic [15:0] first_dwell_ticks;
      logic [15:0] second_dwell_ticks;
      logic [6:0]  fast_duty;
      logic [6:0]  slow_duty;
      logic [6:0]  pivot_duty;
   } cfg_type;

   typedef struct packed {
      logic [6:0] right_duty;
      logic [6:0] left_duty;
      logic [1:0] mode;
      logic       stopped;
   } rsp_type;

   // a zero dwell setting behaves as one tick
   function automatic logic [15:0] dwell_reload(input logic [15:0] ticks);
      return (ticks == 16'd0) ? 16'd1 : ticks;
   endfunction

endpackage

// ----- hdl/grms_ctrl.sv -----
// mode, dwell counters, stop latch and held duties; one update per request
// depends on grms_pkg
`timescale 1ns / 1ps

module grms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  grms_pkg::req_type req,
   input  grms_pkg::cfg_type cfg,
   output grms_pkg::rsp_type nxt
);
   import grms_pkg::*;

   logic [1:0]  mode_ff,   mode_in;
   logic [15:0] first_ff,  first_in;
   logic [15:0] second_ff, second_in;
   logic        stop_ff,   stop_in;
   logic [6:0]  right_ff,  right_in;
   logic [6:0]  left_ff,   left_in;

   always_comb begin
      mode_in   = mode_ff;
      first_in  = first_ff;
      second_in = second_ff;
      stop_in   = stop_ff;
      right_in  = right_ff;
      left_in   = left_ff;

      if (req.func == FUNC_STOP) begin
         stop_in  = 1'b1;
         right_in = DUTY_OFF;
         left_in  = DUTY_OFF;
      end else begin
         if (req.station_button) begin
            mode_in = MODE_DWELL1;
         end
         // enables come from the mode held before this tick
         if (mode_ff == MODE_DWELL1) begin
            first_in = first_ff - 16'd1;
         end
         if (first_in == 16'd0) begin
            first_in = dwell_reload(cfg.first_dwell_ticks);
            mode_in  = MODE_DWELL2;
         end
         if (mode_ff == MODE_DWELL2) begin
            second_in = second_ff - 16'd1;
         end
         if (second_in == 16'd0) begin
            second_in = dwell_reload(cfg.second_dwell_ticks);
            mode_in   = MODE_WAIT;
         end
         if ((mode_ff == MODE_WAIT) && req.resume_button) begin
            mode_in = MODE_FOLLOW;
         end
         if (mode_in == MODE_FOLLOW) begin
            if (req.continue_button) begin
               stop_in = 1'b0;
            end
            if (!stop_in) begin
               if (req.phase_front && !req.phase_back) begin
                  right_in = cfg.fast_duty;
                  left_in  = cfg.slow_duty;
               end else if (!req.phase_front && req.phase_back) begin
                  right_in = cfg.slow_duty;
                  left_in  = cfg.fast_duty;
               end
            end
         end
      end

      // mode override on the motors
      case (mode_in)
         MODE_DWELL1: begin
            right_in = cfg.pivot_duty;
            left_in  = DUTY_OFF;
         end
         MODE_DWELL2: begin
            right_in = DUTY_OFF;
            left_in  = cfg.pivot_duty;
         end
         MODE_WAIT: begin
            right_in = DUTY_OFF;
            left_in  = DUTY_OFF;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FOLLOW;
         first_ff  <= DWELL_RESET;
         second_ff <= DWELL_RESET;
         stop_ff   <= 1'b0;
         right_ff  <= RIGHT_RESET;
         left_ff   <= LEFT_RESET;
      end else if (step) begin
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         stop_ff   <= stop_in;
         right_ff  <= right_in;
         left_ff   <= left_in;
      end
   end

   assign nxt.right_duty = right_in;
   assign nxt.left_duty  = left_in;
   assign nxt.mode       = mode_in;
   assign nxt.stopped    = stop_in;

endmodule

// ----- hdl/guided_robot_mode_and_steering_top.sv -----
// top level of the wire-guided robot mode and steering controller
// depends on grms_pkg, grms_ctrl and guided_robot_mode_and_steering_top_defines.svh
`timescale 1ns / 1ps

// Mode and steering controller for a wire-guided robot. Each request is either
// a periodic tick (req_func 0) carrying button and coil phase levels, or an
// emergency stop event (req_func 1), and it yields exactly one response with
// the two motor duties, the mode and the stop latch as they stand after it.
// A request is registered in the input stage on acceptance, then goes through
// the update logic and lands in the response register. One request is taken
// every cycle for as long as responses are taken; the single state update per
// request is what sets that rate. Configuration (dwell lengths, fast, slow and
// pivot duties) is written through the csr port, which is always ready; write
// it only while no request is in flight. A new dwell length is picked up at the
// next counter reload.

`include "guided_robot_mode_and_steering_top_defines.svh"

module guided_robot_mode_and_steering_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic                                req_station_button,
   input  logic                                req_resume_button,
   input  logic                                req_phase_front,
   input  logic                                req_phase_back,
   input  logic                                req_continue_button,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [6:0]                          rsp_right_duty,
   output logic [6:0]                          rsp_left_duty,
   output logic [1:0]                          rsp_mode,
   output logic                                rsp_stopped,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [grms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [grms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import grms_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   // input stage
   logic    s1_valid_ff;
   req_type s1_req_ff;

   // response stage
   logic    out_valid_ff;
   rsp_type out_ff;

   rsp_type nxt;
   logic    out_free;
   logic    advance;
   logic    req_take;

   // the csr port never pushes back
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_dwell_ticks  <= DWELL_RESET;
         cfg_ff.second_dwell_ticks <= DWELL_RESET;
         cfg_ff.fast_duty          <= FAST_RESET;
         cfg_ff.slow_duty          <= SLOW_RESET;
         cfg_ff.pivot_duty         <= PIVOT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_DWELL:  cfg_ff.first_dwell_ticks  <= csr_wdata;
            CSR_SECOND_DWELL: cfg_ff.second_dwell_ticks <= csr_wdata;
            CSR_FAST_DUTY:    cfg_ff.fast_duty          <= csr_wdata[6:0];
            CSR_SLOW_DUTY:    cfg_ff.slow_duty          <= csr_wdata[6:0];
            CSR_PIVOT_DUTY:   cfg_ff.pivot_duty         <= csr_wdata[6:0];
            default: begin
               // unused indexes are ignored
            end
         endcase
      end
   end

   // response register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the request held in the input stage moves on and updates the state
   assign advance   = s1_valid_ff && out_free;
   // input stage takes a new request when empty or emptying
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.func            <= req_func;
         s1_req_ff.station_button  <= req_station_button;
         s1_req_ff.resume_button   <= req_resume_button;
         s1_req_ff.phase_front     <= req_phase_front;
         s1_req_ff.phase_back      <= req_phase_back;
         s1_req_ff.continue_button <= req_continue_button;
      end
   end

   // state update, one request per step
   grms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (s1_req_ff),
      .cfg   (cfg_ff),
      .nxt   (nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= nxt;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_right_duty = out_ff.right_duty;
   assign rsp_left_duty  = out_ff.left_duty;
   assign rsp_mode       = out_ff.mode;
   assign rsp_stopped    = out_ff.stopped;

   // the input stage only pushes back while it holds a request
   `GRMS_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff, "stall while input stage empty")
   // an accepted request always occupies the input stage next cycle
   `GRMS_ASSERT_NEXT(a_take_fills, clock, reset, req_take, s1_valid_ff, "accepted request was lost")
   // an advancing request always produces a response next cycle
   `GRMS_ASSERT_NEXT(a_advance_out, clock, reset, advance, out_valid_ff, "response missing after update")
   // first dwell pivots on the right motor only
   `GRMS_ASSERT_NOW(a_dwell1_left_off, clock, reset, out_valid_ff && (out_ff.mode == MODE_DWELL1), out_ff.left_duty == DUTY_OFF, "left motor running in first dwell")
   // wait mode stops both motors
   `GRMS_ASSERT_NOW(a_wait_stopped, clock, reset, out_valid_ff && (out_ff.mode == MODE_WAIT), (out_ff.left_duty == DUTY_OFF) && (out_ff.right_duty == DUTY_OFF), "motor running in wait mode")

endmodule

// ----- dv/grms_drive_checker.sv -----
// checker for the mode and steering controller: watches all three channels,
// keeps its own copy of the controller state and compares every response
// depends on grms_pkg
`timescale 1ns / 1ps

module grms_drive_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_func,
   input  logic                             req_station_button,
   input  logic                             req_resume_button,
   input  logic                             req_phase_front,
   input  logic                             req_phase_back,
   input  logic                             req_continue_button,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [6:0]                       rsp_right_duty,
   input  logic [6:0]                       rsp_left_duty,
   input  logic [1:0]                       rsp_mode,
   input  logic                             rsp_stopped,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [grms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grms_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_total,
   output int                               pending_drives
);
   import grms_pkg::*;

   cfg_type     settings;
   logic [1:0]  mode_now;
   logic [15:0] first_left;
   logic [15:0] second_left;
   logic        latched;
   logic [6:0]  right_now;
   logic [6:0]  left_now;

   rsp_type     expected_drive [$];
   req_type     seen_req;
   rsp_type     seen_rsp;
   rsp_type     wanted;

   initial begin
      mismatch_total = 0;
      pending_drives = 0;
   end

   // one tick or stop event applied to the local copy of the controller
   task automatic advance_controller(input req_type r, output rsp_type drive);
      logic [1:0] start_mode;
      start_mode = mode_now;
      if (r.func == FUNC_STOP) begin
         latched   = 1'b1;
         right_now = DUTY_OFF;
         left_now  = DUTY_OFF;
      end else begin
         if (r.station_button)
            mode_now = MODE_DWELL1;
         if (start_mode == MODE_DWELL1)
            first_left = first_left - 16'd1;
         if (first_left == 16'd0) begin
            first_left = (settings.first_dwell_ticks == 16'd0) ? 16'd1
                                                               : settings.first_dwell_ticks;
            mode_now = MODE_DWELL2;
         end
         if (start_mode == MODE_DWELL2)
            second_left = second_left - 16'd1;
         if (second_left == 16'd0) begin
            second_left = (settings.second_dwell_ticks == 16'd0) ? 16'd1
                                                                 : settings.second_dwell_ticks;
            mode_now = MODE_WAIT;
         end
         if (start_mode == MODE_WAIT && r.resume_button)
            mode_now = MODE_FOLLOW;
         if (mode_now == MODE_FOLLOW) begin
            if (r.continue_button)
               latched = 1'b0;
            if (!latched) begin
               if (r.phase_front && !r.phase_back) begin
                  right_now = settings.fast_duty;
                  left_now  = settings.slow_duty;
               end else if (!r.phase_front && r.phase_back) begin
                  right_now = settings.slow_duty;
                  left_now  = settings.fast_duty;
               end
            end
         end
      end
      // the mode overrides the duties after every request
      case (mode_now)
         MODE_DWELL1: begin
            right_now = settings.pivot_duty;
            left_now  = DUTY_OFF;
         end
         MODE_DWELL2: begin
            right_now = DUTY_OFF;
            left_now  = settings.pivot_duty;
         end
         MODE_WAIT: begin
            right_now = DUTY_OFF;
            left_now  = DUTY_OFF;
         end
         default: ;
      endcase
      drive.right_duty = right_now;
      drive.left_duty  = left_now;
      drive.mode       = mode_now;
      drive.stopped    = latched;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.first_dwell_ticks  = DWELL_RESET;
         settings.second_dwell_ticks = DWELL_RESET;
         settings.fast_duty          = FAST_RESET;
         settings.slow_duty          = SLOW_RESET;
         settings.pivot_duty         = PIVOT_RESET;
         mode_now    = MODE_FOLLOW;
         first_left  = DWELL_RESET;
         second_left = DWELL_RESET;
         latched     = 1'b0;
         right_now   = RIGHT_RESET;
         left_now    = LEFT_RESET;
         expected_drive.delete();
         pending_drives <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.right_duty = rsp_right_duty;
            seen_rsp.left_duty  = rsp_left_duty;
            seen_rsp.mode       = rsp_mode;
            seen_rsp.stopped    = rsp_stopped;
            if (expected_drive.size() == 0) begin
               mismatch_total = mismatch_total + 1;
               if (mismatch_total <= 10)
                  $display("%0t unexpected response: right %0d left %0d mode %0d stopped %0d",
                           $realtime, rsp_right_duty, rsp_left_duty, rsp_mode, rsp_stopped);
            end else begin
               wanted = expected_drive.pop_front();
               if (seen_rsp.right_duty !== wanted.right_duty ||
                   seen_rsp.left_duty  !== wanted.left_duty  ||
                   seen_rsp.mode       !== wanted.mode       ||
                   seen_rsp.stopped    !== wanted.stopped) begin
                  mismatch_total = mismatch_total + 1;
                  if (mismatch_total <= 10)
                     $display({"%0t mismatch: expected right %0d left %0d mode %0d ",
                               "stopped %0d, got right %0d left %0d mode %0d stopped %0d"},
                              $realtime, wanted.right_duty, wanted.left_duty, wanted.mode,
                              wanted.stopped, rsp_right_duty, rsp_left_duty, rsp_mode,
                              rsp_stopped);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_DWELL:  settings.first_dwell_ticks  = csr_wdata;
               CSR_SECOND_DWELL: settings.second_dwell_ticks = csr_wdata;
               CSR_FAST_DUTY:    settings.fast_duty          = csr_wdata[6:0];
               CSR_SLOW_DUTY:    settings.slow_duty          = csr_wdata[6:0];
               CSR_PIVOT_DUTY:   settings.pivot_duty         = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen_req.func            = req_func;
            seen_req.station_button  = req_station_button;
            seen_req.resume_button   = req_resume_button;
            seen_req.phase_front     = req_phase_front;
            seen_req.phase_back      = req_phase_back;
            seen_req.continue_button = req_continue_button;
            advance_controller(seen_req, wanted);
            expected_drive.push_back(wanted);
         end
         pending_drives <= expected_drive.size();
      end
   end

endmodule

// ----- dv/guided_robot_mode_and_steering_top_tb.sv -----
// testbench top for the mode and steering controller: clock, reset, request
// stimulus, response back-pressure, register writes and the final verdict
// depends on grms_pkg, grms_drive_checker and guided_robot_mode_and_steering_top
`timescale 1ns / 1ps

module guided_robot_mode_and_steering_top_tb;
   import grms_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, all driven from one payload struct
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;

   // response side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_right_duty;
   logic [6:0] rsp_left_duty;
   logic [1:0] rsp_mode;
   logic       rsp_stopped;

   // register write side
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FIRST_DWELL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_total;
   int pending_drives;

   // knobs shared between the stimulus and the response process
   bit steady_flow   = 1'b0;   // no idling on either side
   bit squeeze_asked = 1'b0;   // ask the receiver for one long hold-off
   bit squeeze_done  = 1'b0;

   always #5 clock = ~clock;

   guided_robot_mode_and_steering_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_item.func),
      .req_station_button  (req_item.station_button),
      .req_resume_button   (req_item.resume_button),
      .req_phase_front     (req_item.phase_front),
      .req_phase_back      (req_item.phase_back),
      .req_continue_button (req_item.continue_button),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_right_duty      (rsp_right_duty),
      .rsp_left_duty       (rsp_left_duty),
      .rsp_mode            (rsp_mode),
      .rsp_stopped         (rsp_stopped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   grms_drive_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_item.func),
      .req_station_button  (req_item.station_button),
      .req_resume_button   (req_item.resume_button),
      .req_phase_front     (req_item.phase_front),
      .req_phase_back      (req_item.phase_back),
      .req_continue_button (req_item.continue_button),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_right_duty      (rsp_right_duty),
      .rsp_left_duty       (rsp_left_duty),
      .rsp_mode            (rsp_mode),
      .rsp_stopped         (rsp_stopped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_total      (mismatch_total),
      .pending_drives      (pending_drives)
   );

   function automatic req_type make_req(input logic func, input logic station,
                                        input logic resume, input logic front,
                                        input logic back, input logic cont);
      req_type r;
      r.func            = func;
      r.station_button  = station;
      r.resume_button   = resume;
      r.phase_front     = front;
      r.phase_back      = back;
      r.continue_button = cont;
      return r;
   endfunction

   // mostly plausible ticks: rare station presses so the dwell counters get to
   // run out, now and then a stop event, and a slice of fully random noise
   function automatic req_type random_req();
      req_type     r;
      logic [31:0] noise;
      if ($urandom_range(99) < 10) begin
         noise = $urandom;
         r     = noise[5:0];
      end else begin
         r.func            = ($urandom_range(99) < 5) ? FUNC_STOP : FUNC_TICK;
         r.station_button  = ($urandom_range(99) < 3);
         r.resume_button   = ($urandom_range(99) < 30);
         r.phase_front     = 1'($urandom_range(1));
         r.phase_back      = 1'($urandom_range(1));
         r.continue_button = ($urandom_range(99) < 25);
      end
      return r;
   endfunction

   // offer one request and hold it until the block takes it; valid is only
   // lowered in the random idle cycles that come before an offer
   task automatic send_request(input req_type r);
      while (!steady_flow && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_request(random_req());
   endtask

   // write all five registers back to back, valid held high across them
   task automatic program_settings(input logic [15:0] first_ticks,
                                   input logic [15:0] second_ticks,
                                   input logic [15:0] fast, input logic [15:0] slow,
                                   input logic [15:0] pivot);
      logic [CSR_INDEX_W-1:0] slot [5];
      logic [15:0]            word [5];
      int                     k;
      slot[0] = CSR_FIRST_DWELL;  word[0] = first_ticks;
      slot[1] = CSR_SECOND_DWELL; word[1] = second_ticks;
      slot[2] = CSR_FAST_DUTY;    word[2] = fast;
      slot[3] = CSR_SLOW_DUTY;    word[3] = slow;
      slot[4] = CSR_PIVOT_DUTY;   word[4] = pivot;
      for (k = 0; k < 5; k++) begin
         csr_valid <= 1'b1;
         csr_index <= slot[k];
         csr_wdata <= word[k];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // stop offering, wait for every outstanding response, then a few spare
   // cycles to cover the two-stage pipeline
   task automatic wait_for_drain();
      int guard;
      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending_drives != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // response back-pressure, with one long counted hold-off on request so
   // that the pipeline fills and the block has to stall its input
   initial begin
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (squeeze_asked && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
         end else begin
            rsp_stall <= (!steady_flow && $urandom_range(99) < 27);
            @(posedge clock);
         end
      end
   end

   // main stimulus and verdict
   initial begin
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extreme duties; the counters still start from their reset length
      program_settings(16'd3, 16'd2, 16'd100, 16'd0, 16'd100);

      // steering in follow mode: none, front only, back only, both
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
      // resume has no effect in follow, continue with nothing latched
      send_request(make_req(FUNC_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
      // emergency stop ignores every other field
      send_request(make_req(FUNC_STOP, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
      // latched: steering blocked until continue is pressed
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_request(make_req(FUNC_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      // station forces first dwell; continue outside follow keeps the latch
      send_request(make_req(FUNC_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      // stop while pivoting: the pivot duty comes straight back
      send_request(make_req(FUNC_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_request(make_req(FUNC_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_request(make_req(FUNC_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));

      // random run through the long reset-length dwells
      run_random(285);
      wait_for_drain();

      // zero dwell lengths reload as one; duties swapped to the other extreme,
      // and neither side idles for the whole phase
      steady_flow = 1'b1;
      program_settings(16'd0, 16'd0, 16'd0, 16'd100, 16'd0);
      run_random(250);
      wait_for_drain();
      steady_flow = 1'b0;

      // short random dwells with random duties; one phase gets the hold-off
      for (phase = 0; phase < 5; phase++) begin
         program_settings(16'($urandom_range(6)), 16'($urandom_range(6)),
                          16'($urandom_range(100)), 16'($urandom_range(100)),
                          16'($urandom_range(100)));
         if (phase == 1)
            squeeze_asked = 1'b1;
         run_random(200);
         wait_for_drain();
      end

      // longest dwells last so they cannot starve later phases; duty words with
      // bits above the 7-bit field, which the block masks off
      program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0080, 16'd101);
      run_random(150);
      wait_for_drain();

      if (mismatch_total == 0 && pending_drives == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
